// ----- rtl/sce_pkg.sv -----
// shared types and op codes for the sound channel envelope, length and timer unit
// no dependencies
package sce_pkg;

   localparam logic [2:0] OP_ENV_RELOAD    = 3'd0;
   localparam logic [2:0] OP_LENGTH_RELOAD = 3'd1;
   localparam logic [2:0] OP_PERIOD_LOAD   = 3'd2;
   localparam logic [2:0] OP_TIMER_RELOAD  = 3'd3;
   localparam logic [2:0] OP_ENV_TICK      = 3'd4;
   localparam logic [2:0] OP_LENGTH_TICK   = 3'd5;
   localparam logic [2:0] OP_ADVANCE       = 3'd6;

   localparam logic [3:0]  VOL_MAX     = 4'hF;
   localparam logic [6:0]  LENGTH_FULL = 7'd64;
   localparam logic [11:0] TIMER_BASE  = 12'd2048;

   localparam logic [2:0] CSR_ADDR_LENGTH_ENABLE = 3'd0;

   typedef struct packed {
      logic [3:0]  volume_level;
      logic [2:0]  env_period;
      logic [2:0]  env_countdown;
      logic        env_rising;
      logic        env_stopped;
      logic [6:0]  length_count;
      logic        length_disabled;
      logic [10:0] freq_period;
      logic [13:0] freq_countdown;
   } chan_state_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  env_control;
      logic [5:0]  length_value;
      logic [7:0]  period_low;
      logic [2:0]  period_high;
      logic [5:0]  tick_count;
   } chan_item_type;

endpackage

// ----- rtl/sce_core.sv -----
// next-state logic of the channel: envelope, length counter and frequency timer
// depends on sce_pkg
module sce_core
   import sce_pkg::*;
(
   input  chan_state_type cur,
   input  chan_item_type  item,
   input  logic           length_enable,
   output chan_state_type nxt,
   output logic           expired
);

   logic [13:0] reload;
   logic [2:0]  cd_dec;
   logic [15:0] diff;
   logic [15:0] wrapped;
   logic        under;

   // (2048 - period) * 4
   assign reload  = {TIMER_BASE - {1'b0, cur.freq_period}, 2'b00};
   assign cd_dec  = (cur.env_countdown != 3'd0) ? cur.env_countdown - 3'd1 : 3'd0;
   assign diff    = {2'b00, cur.freq_countdown} - {10'd0, item.tick_count};
   assign under   = cur.freq_countdown < {8'd0, item.tick_count};
   assign wrapped = {2'b00, reload} + diff;

   always_comb begin
      nxt     = cur;
      expired = 1'b0;
      case (item.op)
         OP_ENV_RELOAD: begin
            nxt.env_period    = item.env_control[2:0];
            nxt.env_countdown = item.env_control[2:0];
            if (item.env_control[2:0] != 3'd0) begin
               nxt.env_stopped = 1'b0;
            end
            nxt.volume_level = item.env_control[7:4];
            nxt.env_rising   = item.env_control[3];
         end
         OP_LENGTH_RELOAD: begin
            nxt.length_count    = LENGTH_FULL - {1'b0, item.length_value};
            nxt.length_disabled = 1'b0;
         end
         OP_PERIOD_LOAD: begin
            nxt.freq_period = {item.period_high, item.period_low};
         end
         OP_TIMER_RELOAD: begin
            nxt.freq_countdown = reload;
         end
         OP_ENV_TICK: begin
            nxt.env_countdown = cd_dec;
            if (cd_dec == 3'd0 && !cur.env_stopped) begin
               if (cur.env_rising) begin
                  if (cur.volume_level != VOL_MAX) begin
                     nxt.volume_level = cur.volume_level + 4'd1;
                  end
               end else if (cur.volume_level != 4'd0) begin
                  nxt.volume_level = cur.volume_level - 4'd1;
               end
               nxt.env_countdown = cur.env_period;
               if (cur.env_period == 3'd0) begin
                  nxt.env_stopped = 1'b1;
               end
            end
         end
         OP_LENGTH_TICK: begin
            if (length_enable && cur.length_count != 7'd0) begin
               nxt.length_count = cur.length_count - 7'd1;
               if (cur.length_count == 7'd1) begin
                  nxt.length_disabled = 1'b1;
               end
            end
         end
         OP_ADVANCE: begin
            if (under) begin
               expired = 1'b1;
               // one reload with carry, clamp at zero if still negative
               nxt.freq_countdown = wrapped[15] ? 14'd0 : wrapped[13:0];
            end else begin
               nxt.freq_countdown = diff[13:0];
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- rtl/sound_channel_envelope_length_timer_unit.sv -----
// sound channel timing core: volume envelope, length counter, frequency timer
// an accepted item's result is registered into the output register and shows in the next cycle
// throughput: one item per cycle while the result side does not stall; the channel state register is updated on accept
// reset: synchronous, active high; clears all channel state, length_enable and rsp_valid
// depends on sce_pkg and sce_core
module sound_channel_envelope_length_timer_unit
   import sce_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [7:0]  req_env_control,
   input  logic [5:0]  req_length_value,
   input  logic [7:0]  req_period_low,
   input  logic [2:0]  req_period_high,
   input  logic [5:0]  req_tick_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_volume,
   output logic        rsp_channel_off,
   output logic        rsp_envelope_off,
   output logic        rsp_timer_expired,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   chan_state_type state_ff, state_in;
   chan_item_type  item;
   logic           length_enable_ff;
   logic           expired;
   logic           accept;
   logic           csr_write;
   logic           rsp_valid_ff;
   logic [3:0]     volume_ff;
   logic           channel_off_ff, envelope_off_ff, timer_expired_ff;

   assign item = '{op: req_op, env_control: req_env_control,
                   length_value: req_length_value, period_low: req_period_low,
                   period_high: req_period_high, tick_count: req_tick_count};

   sce_core u_core (
      .cur           (state_ff),
      .item          (item),
      .length_enable (length_enable_ff),
      .nxt           (state_in),
      .expired       (expired)
   );

   // output register frees up as soon as its result is taken
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         volume_ff        <= state_in.volume_level;
         channel_off_ff   <= state_in.length_disabled;
         envelope_off_ff  <= state_in.env_stopped;
         timer_expired_ff <= expired;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_volume        = volume_ff;
   assign rsp_channel_off   = channel_off_ff;
   assign rsp_envelope_off  = envelope_off_ff;
   assign rsp_timer_expired = timer_expired_ff;

   // configuration register
   assign csr_write = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_enable_ff <= 1'b0;
      end else if (csr_write && csr_paddr == CSR_ADDR_LENGTH_ENABLE) begin
         length_enable_ff <= csr_pwdata[0];
      end
   end

   assign csr_prdata = (csr_paddr == CSR_ADDR_LENGTH_ENABLE) ? {31'd0, length_enable_ff}
                                                           : 32'd0;
   assign csr_pready = 1'b1;

   a_length_reload_enables : assert property (@(posedge clock) disable iff (reset)
      accept && req_op == OP_LENGTH_RELOAD |=> rsp_valid && !rsp_channel_off)
      else $error("length reload did not re-enable the channel");

   a_env_reload_restarts : assert property (@(posedge clock) disable iff (reset)
      accept && req_op == OP_ENV_RELOAD && req_env_control[2:0] != 3'd0
      |=> !rsp_envelope_off)
      else $error("envelope reload with nonzero period left envelope stopped");

   a_expired_only_advance : assert property (@(posedge clock) disable iff (reset)
      accept && req_op != OP_ADVANCE |=> !rsp_timer_expired)
      else $error("timer expired reported on a non-advance op");

   a_length_in_range : assert property (@(posedge clock) disable iff (reset)
      state_ff.length_count <= LENGTH_FULL)
      else $error("length count above full scale");

endmodule

// ----- tb/tb_sound_channel_envelope_length_timer_unit.sv -----
// testbench for the sound channel envelope, length and timer unit
// directed table (some rows with typed-in status) and random transfers checked against an in-bench channel predictor
// depends on sce_pkg and sound_channel_envelope_length_timer_unit
module tb_sound_channel_envelope_length_timer_unit
   import sce_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] OP_UNUSED       = 3'd7;
   localparam int         TIMER_SCALE     = 4;
   localparam int         WATCHDOG_LIMIT  = 5000;
   localparam int         NUM_SEGMENTS    = 6;
   localparam int         SEGMENT_ITEMS   = 275;
   localparam int         NUM_DIRECTED    = 27;

   typedef struct packed {
      logic [3:0] volume;
      logic       channel_off;
      logic       envelope_off;
      logic       timer_expired;
   } chan_status_type;

   typedef enum logic {ROW_ITEM, ROW_CSR_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type    kind;
      logic            csr_value;
      chan_item_type   item;
      logic            typed;
      chan_status_type status;
   } stim_row_type;

   // typed-in status only where it is obvious; the rest goes through the predictor
   localparam stim_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{ROW_ITEM, 1'b0, '{OP_UNUSED, 8'h00, 6'd0, 8'h00, 3'd0, 6'd0}, 1'b1,
        '{4'd0, 1'b0, 1'b0, 1'b0}},
      '{ROW_ITEM, 1'b0, '{OP_ENV_TICK, 8'h00, 6'd0, 8'h00, 3'd0, 6'd0}, 1'b1,
        '{4'd0, 1'b0, 1'b1, 1'b0}},
      '{ROW_ITEM, 1'b0, '{OP_ENV_RELOAD, 8'h00, 6'd0, 8'h00, 3'd0, 6'd0}, 1'b1,
        '{4'd0, 1'b0, 1'b1, 1'b0}},
      '{ROW_ITEM, 1'b0, '{OP_ENV_RELOAD, 8'hF9, 6'd0, 8'h00, 3'd0, 6'd0}, 1'b1,
        '{4'd15, 1'b0, 1'b0, 1'b0}},
      '{ROW_ITEM, 1'b0, '{OP_ENV_TICK, 8'h00, 6'd0, 8'h00, 3'd0, 6'd0}, 1'b0, '0},
      '{ROW_ITEM, 1'b0, '{OP_ENV_RELOAD, 8'h07, 6'd0, 8'h00, 3'd0, 6'd0}, 1'b1,
        '{4'd0, 1'b0, 1'b0, 1'b0}},
      '{ROW_ITEM, 1'b0, '{OP_ENV_TICK, 8'hFF, 6'h3F, 8'hFF, 3'h7, 6'h3F}, 1'b0, '0},
      '{ROW_ITEM, 1'b0, '{OP_ENV_RELOAD, 8'h18, 6'd0, 8'h00, 3'd0, 6'd0}, 1'b0, '0},
      '{ROW_ITEM, 1'b0, '{OP_ENV_TICK, 8'h00, 6'd0, 8'h00, 3'd0, 6'd0}, 1'b0, '0},
      '{ROW_ITEM, 1'b0, '{OP_ENV_TICK, 8'h00, 6'd0, 8'h00, 3'd0, 6'd0}, 1'b0, '0},
      '{ROW_ITEM, 1'b0, '{OP_LENGTH_RELOAD, 8'h00, 6'd63, 8'h00, 3'd0, 6'd0}, 1'b0, '0},
      '{ROW_ITEM, 1'b0, '{OP_LENGTH_TICK, 8'h00, 6'd0, 8'h00, 3'd0, 6'd0}, 1'b0, '0},
      '{ROW_CSR_WRITE, 1'b1, '0, 1'b0, '0},
      '{ROW_ITEM, 1'b0, '{OP_LENGTH_TICK, 8'h00, 6'd0, 8'h00, 3'd0, 6'd0}, 1'b0, '0},
      '{ROW_ITEM, 1'b0, '{OP_LENGTH_TICK, 8'h00, 6'd0, 8'h00, 3'd0, 6'd0}, 1'b0, '0},
      '{ROW_ITEM, 1'b0, '{OP_LENGTH_RELOAD, 8'h00, 6'd0, 8'h00, 3'd0, 6'd0}, 1'b0, '0},
      '{ROW_ITEM, 1'b0, '{OP_PERIOD_LOAD, 8'h00, 6'd0, 8'hFF, 3'h7, 6'd0}, 1'b0, '0},
      '{ROW_ITEM, 1'b0, '{OP_TIMER_RELOAD, 8'h00, 6'd0, 8'h00, 3'd0, 6'd0}, 1'b0, '0},
      '{ROW_ITEM, 1'b0, '{OP_ADVANCE, 8'h00, 6'd0, 8'h00, 3'd0, 6'h3F}, 1'b0, '0},
      '{ROW_ITEM, 1'b0, '{OP_ADVANCE, 8'h00, 6'd0, 8'h00, 3'd0, 6'd0}, 1'b0, '0},
      '{ROW_ITEM, 1'b0, '{OP_ADVANCE, 8'h00, 6'd0, 8'h00, 3'd0, 6'd1}, 1'b0, '0},
      '{ROW_ITEM, 1'b0, '{OP_PERIOD_LOAD, 8'h00, 6'd0, 8'h00, 3'd0, 6'd0}, 1'b0, '0},
      '{ROW_ITEM, 1'b0, '{OP_TIMER_RELOAD, 8'h00, 6'd0, 8'h00, 3'd0, 6'd0}, 1'b0, '0},
      '{ROW_ITEM, 1'b0, '{OP_ADVANCE, 8'h00, 6'd0, 8'h00, 3'd0, 6'h3F}, 1'b0, '0},
      '{ROW_ITEM, 1'b0, '{OP_UNUSED, 8'hFF, 6'h3F, 8'hFF, 3'h7, 6'h3F}, 1'b0, '0},
      '{ROW_ITEM, 1'b0, '{OP_ENV_RELOAD, 8'hF0, 6'd0, 8'h00, 3'd0, 6'd0}, 1'b0, '0},
      '{ROW_CSR_WRITE, 1'b0, '0, 1'b0, '0}
   };

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [2:0]  req_op           = '0;
   logic [7:0]  req_env_control  = '0;
   logic [5:0]  req_length_value = '0;
   logic [7:0]  req_period_low   = '0;
   logic [2:0]  req_period_high  = '0;
   logic [5:0]  req_tick_count   = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [3:0]  rsp_volume;
   logic        rsp_channel_off;
   logic        rsp_envelope_off;
   logic        rsp_timer_expired;
   logic        csr_psel         = 1'b0;
   logic        csr_penable      = 1'b0;
   logic        csr_pwrite       = 1'b0;
   logic [2:0]  csr_paddr        = '0;
   logic [31:0] csr_pwdata       = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   chan_state_type  chan_model          = '0;
   logic            model_length_enable = 1'b0;
   chan_status_type pending_status[$];
   int              error_count = 0;
   int              idle_mode   = 0;
   int unsigned     send_idle_pct  [3] = '{34, 50, 0};
   int unsigned     recv_stall_pct [3] = '{50, 34, 0};

   sound_channel_envelope_length_timer_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_env_control   (req_env_control),
      .req_length_value  (req_length_value),
      .req_period_low    (req_period_low),
      .req_period_high   (req_period_high),
      .req_tick_count    (req_tick_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_volume        (rsp_volume),
      .rsp_channel_off   (rsp_channel_off),
      .rsp_envelope_off  (rsp_envelope_off),
      .rsp_timer_expired (rsp_timer_expired),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // applies one item to the channel state copy and returns the status it reports
   function automatic chan_status_type predict_channel(input chan_item_type it);
      chan_status_type st;
      int              reload;
      int              t;
      st = '0;
      reload = (int'(TIMER_BASE) - int'(chan_model.freq_period)) * TIMER_SCALE;
      case (it.op)
         OP_ENV_RELOAD: begin
            chan_model.env_period    = it.env_control[2:0];
            chan_model.env_countdown = it.env_control[2:0];
            // a zero period leaves the stopped flag alone
            if (it.env_control[2:0] != 3'd0)
               chan_model.env_stopped = 1'b0;
            chan_model.volume_level = it.env_control[7:4];
            chan_model.env_rising   = it.env_control[3];
         end
         OP_LENGTH_RELOAD: begin
            chan_model.length_count    = LENGTH_FULL - {1'b0, it.length_value};
            chan_model.length_disabled = 1'b0;
         end
         OP_PERIOD_LOAD: begin
            chan_model.freq_period = {it.period_high, it.period_low};
         end
         OP_TIMER_RELOAD: begin
            chan_model.freq_countdown = 14'(reload);
         end
         OP_ENV_TICK: begin
            if (chan_model.env_countdown != 3'd0)
               chan_model.env_countdown = chan_model.env_countdown - 3'd1;
            if (chan_model.env_countdown == 3'd0 && !chan_model.env_stopped) begin
               if (chan_model.env_rising) begin
                  if (chan_model.volume_level != VOL_MAX)
                     chan_model.volume_level = chan_model.volume_level + 4'd1;
               end else if (chan_model.volume_level != 4'd0) begin
                  chan_model.volume_level = chan_model.volume_level - 4'd1;
               end
               chan_model.env_countdown = chan_model.env_period;
               if (chan_model.env_period == 3'd0)
                  chan_model.env_stopped = 1'b1;
            end
         end
         OP_LENGTH_TICK: begin
            if (model_length_enable && chan_model.length_count != 7'd0) begin
               chan_model.length_count = chan_model.length_count - 7'd1;
               if (chan_model.length_count == 7'd0)
                  chan_model.length_disabled = 1'b1;
            end
         end
         OP_ADVANCE: begin
            t = int'(chan_model.freq_countdown) - int'(it.tick_count);
            if (t < 0) begin
               // one reload with carry, then clamp if still below zero
               t = reload + t;
               st.timer_expired = 1'b1;
               if (t < 0)
                  t = 0;
            end
            chan_model.freq_countdown = 14'(t);
         end
         default: begin
         end
      endcase
      st.volume       = chan_model.volume_level;
      st.channel_off  = chan_model.length_disabled;
      st.envelope_off = chan_model.env_stopped;
      return st;
   endfunction

   function automatic chan_item_type random_channel_item();
      chan_item_type it;
      int unsigned   pick;
      it.env_control  = 8'($urandom());
      it.length_value = 6'($urandom());
      it.period_low   = 8'($urandom());
      it.period_high  = 3'($urandom());
      it.tick_count   = 6'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 12)
         it.op = OP_ENV_RELOAD;
      else if (pick < 22)
         it.op = OP_LENGTH_RELOAD;
      else if (pick < 32)
         it.op = OP_PERIOD_LOAD;
      else if (pick < 42)
         it.op = OP_TIMER_RELOAD;
      else if (pick < 58)
         it.op = OP_ENV_TICK;
      else if (pick < 74)
         it.op = OP_LENGTH_TICK;
      else if (pick < 97)
         it.op = OP_ADVANCE;
      else
         it.op = OP_UNUSED;
      // short lengths so the counter actually runs out
      if ($urandom_range(0, 1) == 0)
         it.length_value = 6'($urandom_range(48, 63));
      // long periods give short reloads, so the timer wraps and underflows often
      if ($urandom_range(0, 9) < 6) begin
         it.period_high = 3'h7;
         it.period_low  = 8'($urandom_range(192, 255));
      end
      return it;
   endfunction

   task automatic send_item(input chan_item_type it, input logic use_typed,
                            input chan_status_type typed_status);
      chan_status_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct[idle_mode]) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= it.op;
      req_env_control  <= it.env_control;
      req_length_value <= it.length_value;
      req_period_low   <= it.period_low;
      req_period_high  <= it.period_high;
      req_tick_count   <= it.tick_count;
      do
         @(posedge clock);
      while (req_stall);
      predicted = predict_channel(it);
      pending_status.push_back(use_typed ? typed_status : predicted);
   endtask

   task automatic drain_channel();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_status.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // write length_enable, then read it back
   task automatic write_length_enable(input logic value);
      logic [31:0] wdata;
      wdata    = $urandom();
      wdata[0] = value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_LENGTH_ENABLE;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      model_length_enable = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      if (csr_prdata[0] !== value) begin
         $error("length_enable readback mismatch: expected %0d, got %0d", value, csr_prdata[0]);
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // result side: random stall and in-order comparison
   always @(posedge clock) begin
      chan_status_type want;
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct[idle_mode]);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_status.size() == 0) begin
            $error("result transfer with no pending expectation");
            error_count++;
         end else begin
            want = pending_status.pop_front();
            if (rsp_volume !== want.volume) begin
               $error("volume mismatch: expected %0d, got %0d", want.volume, rsp_volume);
               error_count++;
            end
            if (rsp_channel_off !== want.channel_off) begin
               $error("channel_off mismatch: expected %0d, got %0d",
                      want.channel_off, rsp_channel_off);
               error_count++;
            end
            if (rsp_envelope_off !== want.envelope_off) begin
               $error("envelope_off mismatch: expected %0d, got %0d",
                      want.envelope_off, rsp_envelope_off);
               error_count++;
            end
            if (rsp_timer_expired !== want.timer_expired) begin
               $error("timer_expired mismatch: expected %0d, got %0d",
                      want.timer_expired, rsp_timer_expired);
               error_count++;
            end
         end
      end
   end

   // counts cycles with no transfer on any port
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_psel && csr_penable))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      stim_row_type row;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.kind == ROW_CSR_WRITE) begin
            drain_channel();
            write_length_enable(row.csr_value);
         end else begin
            send_item(row.item, row.typed, row.status);
         end
      end

      for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
         drain_channel();
         idle_mode = seg / 2;
         write_length_enable(seg % 2 == 0);
         for (int n = 0; n < SEGMENT_ITEMS; n++)
            send_item(random_channel_item(), 1'b0, '0);
      end

      drain_channel();
      repeat (4) @(posedge clock);
      if (error_count == 0 && pending_status.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
